// ----- hdl/collision_lease_registry_defines.svh -----
// assertion macros shared by the lease registry checkers
// expects clk and arst_n in the scope where a macro is used
`ifndef COLLISION_LEASE_REGISTRY_DEFINES_SVH
`define COLLISION_LEASE_REGISTRY_DEFINES_SVH

// same-cycle implication, checked while out of reset
`define CLR_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked while out of reset
`define CLR_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- hdl/clr_pkg.sv -----
// shared types and constants of the collision lease registry
// no dependencies; used by the top level and its checker
package clr_pkg;

	localparam int ENTRIES = 16;
	localparam int OWNERS = 4;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	typedef enum logic [1:0] {
		CMD_ACQUIRE = 2'd0,
		CMD_RELEASE = 2'd1,
		CMD_QUERY = 2'd2
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_READ_FAIL = 2'd1,
		ST_NOTHING = 2'd2,
		ST_FULL = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		REG_NO_COLLIDE_MASK = 2'd0,
		REG_INVALID_BODY = 2'd1
	} reg_idx_t;

	typedef enum logic [1:0] {
		FSM_IDLE,
		FSM_SCAN,
		FSM_DECIDE
	} fsm_t;

	typedef struct packed {
		logic [7:0] world;
		logic [31:0] body;
		logic [31:0] motion;
		logic [31:0] cobj;
		logic [31:0] onode;
		logic [OWNERS-1:0] owners;
		logic was_disabled;
	} entry_t;

	function automatic logic [2:0] count_owners(logic [OWNERS-1:0] m);
		logic [5:0] c;
		c = '0;
		for (int i = 0; i < OWNERS; i++) begin
			c = c + 6'(m[i]);
		end
		return c[2:0];
	endfunction

endpackage

// ----- hdl/collision_lease_registry.sv -----
// lease table keyed by world and body, entry data held in one synchronous ram
// depends on clr_pkg for types, codes and table sizes
//
// channel  direction  handshake              payload
// in       to block   in_valid / in_stall    command .. current_filter
// out      from block out_valid / out_stall  status .. lease_held
// cfg      to block   cfg_valid / cfg_ready  cfg_index, cfg_data
//
// each item steps through accept, one ram read per entry with the registered read
// data compared as it returns, and a decide step that writes back
// entries are read one a cycle from the single-port table ram during the scan
// reset empties the table at once through per-entry valid flops, no clearing pass
// the next item is taken while a result waits; decide holds while out is stalled
module collision_lease_registry (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  command,
	input  logic        world_present,
	input  logic [7:0]  world_id,
	input  logic [31:0] body_id,
	input  logic [1:0]  owner,
	input  logic        snapshot_ok,
	input  logic [31:0] motion_index,
	input  logic [31:0] collision_object_id,
	input  logic [31:0] owner_node_id,
	input  logic        filter_ok,
	input  logic [31:0] current_filter,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic        already_held,
	output logic        first_lease,
	output logic        stale_dropped,
	output logic        fully_released,
	output logic        was_disabled_before,
	output logic [2:0]  lease_count,
	output logic [31:0] filter_before,
	output logic [31:0] filter_after,
	output logic        filter_write,
	output logic        lease_held,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [1:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	typedef struct packed {
		clr_pkg::status_t status;
		logic already_held;
		logic first_lease;
		logic stale_dropped;
		logic fully_released;
		logic was_disabled_before;
		logic [2:0] lease_count;
		logic [31:0] filter_before;
		logic [31:0] filter_after;
		logic filter_write;
		logic lease_held;
	} result_t;

	clr_pkg::fsm_t state_q, state_d;

	// configuration
	logic [31:0] nc_mask_q;
	logic [31:0] inv_body_q;

	// captured item
	logic [1:0]  cmd_q;
	logic        wp_q;
	logic [7:0]  world_q;
	logic [31:0] body_q;
	logic [1:0]  owner_q;
	logic        snap_ok_q;
	logic [31:0] motion_q;
	logic [31:0] cobj_q;
	logic [31:0] onode_q;
	logic        filt_ok_q;
	logic [31:0] cur_q;

	// table
	clr_pkg::entry_t mem_q [clr_pkg::ENTRIES];
	logic [clr_pkg::ENTRIES-1:0] valid_q;
	clr_pkg::entry_t rd_data_s1;
	logic rd_vld_s1;
	logic [clr_pkg::IDX_W-1:0] rd_idx_s1;
	logic [clr_pkg::IDX_W-1:0] rd_addr;
	logic rd_en;
	logic mem_we;
	logic [clr_pkg::IDX_W-1:0] mem_wa;
	clr_pkg::entry_t mem_wd;

	// scan results
	logic [clr_pkg::CNT_W-1:0] cnt_q;
	logic [clr_pkg::ENTRIES-1:0] match_q;
	logic found_q;
	logic [clr_pkg::IDX_W-1:0] hit_idx_q;
	clr_pkg::entry_t hit_data_q;
	logic held_q;
	logic free_q;
	logic [clr_pkg::IDX_W-1:0] free_idx_q;
	logic free2_q;
	logic [clr_pkg::IDX_W-1:0] free2_idx_q;

	logic in_acc;
	logic out_free;
	logic commit;
	logic [clr_pkg::OWNERS-1:0] owner_bit;
	logic owner_ok;
	logic cmp_valid;
	logic cmp_body;
	logic cmp_key;
	logic cmp_held;

	// decide
	result_t res;
	result_t res_q;
	logic out_valid_q;
	logic [clr_pkg::ENTRIES-1:0] clr_mask;
	logic [clr_pkg::ENTRIES-1:0] set_mask;
	logic id_ok;
	logic stale;
	logic [31:0] after_or;
	logic ins_ok;
	logic [clr_pkg::IDX_W-1:0] ins_idx;
	logic [clr_pkg::OWNERS-1:0] add_owners;
	logic [clr_pkg::OWNERS-1:0] rel_owners;
	logic [31:0] rel_after;

	assign cfg_ready = 1'b1;
	assign in_acc = in_valid && !in_stall;
	assign out_free = !out_valid_q || !out_stall;
	assign owner_bit = clr_pkg::OWNERS'(1) << owner_q;
	assign owner_ok = 32'(owner_q) < 32'(clr_pkg::OWNERS);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			clr_pkg::FSM_IDLE: begin
				if (in_valid) state_d = clr_pkg::FSM_SCAN;
			end
			clr_pkg::FSM_SCAN: begin
				if (cnt_q == clr_pkg::CNT_W'(clr_pkg::ENTRIES)) state_d = clr_pkg::FSM_DECIDE;
			end
			clr_pkg::FSM_DECIDE: begin
				if (out_free) state_d = clr_pkg::FSM_IDLE;
			end
			default: state_d = clr_pkg::FSM_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		in_stall = 1'b1;
		rd_en = 1'b0;
		commit = 1'b0;
		unique case (state_q)
			clr_pkg::FSM_IDLE: in_stall = 1'b0;
			clr_pkg::FSM_SCAN: rd_en = cnt_q < clr_pkg::CNT_W'(clr_pkg::ENTRIES);
			clr_pkg::FSM_DECIDE: commit = out_free;
			default: in_stall = 1'b1;
		endcase
	end

	assign rd_addr = cnt_q[clr_pkg::IDX_W-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= clr_pkg::FSM_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nc_mask_q <= 32'h0000_4000;
			inv_body_q <= 32'h7FFF_FFFF;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				clr_pkg::REG_NO_COLLIDE_MASK: nc_mask_q <= cfg_data;
				clr_pkg::REG_INVALID_BODY: inv_body_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cmd_q <= command;
			wp_q <= world_present;
			world_q <= world_id;
			body_q <= body_id;
			owner_q <= owner;
			snap_ok_q <= snapshot_ok;
			motion_q <= motion_index;
			cobj_q <= collision_object_id;
			onode_q <= owner_node_id;
			filt_ok_q <= filter_ok;
			cur_q <= current_filter;
		end
	end

	// table ram
	always_ff @(posedge clk) begin
		if (mem_we) mem_q[mem_wa] <= mem_wd;
	end

	always_ff @(posedge clk) begin
		if (rd_en) rd_data_s1 <= mem_q[rd_addr];
	end

	// compare of the entry read last cycle
	always_comb begin
		cmp_valid = valid_q[rd_idx_s1];
		cmp_body = rd_data_s1.body == body_q;
		cmp_key = cmp_valid && cmp_body && (rd_data_s1.world == world_q);
		cmp_held = cmp_valid && cmp_body && (|(rd_data_s1.owners & owner_bit));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			rd_idx_s1 <= '0;
			match_q <= '0;
			found_q <= 1'b0;
			held_q <= 1'b0;
			free_q <= 1'b0;
			free2_q <= 1'b0;
		end else if (in_acc) begin
			cnt_q <= '0;
			rd_vld_s1 <= 1'b0;
			match_q <= '0;
			found_q <= 1'b0;
			held_q <= 1'b0;
			free_q <= 1'b0;
			free2_q <= 1'b0;
		end else begin
			rd_vld_s1 <= rd_en;
			if (rd_en) begin
				rd_idx_s1 <= rd_addr;
				cnt_q <= cnt_q + 1'b1;
			end
			if (rd_vld_s1) begin
				match_q[rd_idx_s1] <= cmp_key;
				if (cmp_key && !found_q) found_q <= 1'b1;
				if (cmp_held) held_q <= 1'b1;
				if (!cmp_valid && !free_q) free_q <= 1'b1;
				// a slot that a stale drop would free also counts here
				if ((!cmp_valid || cmp_key) && !free2_q) free2_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_vld_s1) begin
			if (cmp_key && !found_q) begin
				hit_idx_q <= rd_idx_s1;
				hit_data_q <= rd_data_s1;
			end
			if (!cmp_valid && !free_q) free_idx_q <= rd_idx_s1;
			if ((!cmp_valid || cmp_key) && !free2_q) free2_idx_q <= rd_idx_s1;
		end
	end

	// decide
	always_comb begin
		id_ok = (hit_data_q.motion == motion_q) && (hit_data_q.cobj == cobj_q) &&
			(hit_data_q.onode == onode_q);
		stale = found_q && !id_ok;
		after_or = cur_q | nc_mask_q;
		ins_ok = stale ? free2_q : free_q;
		ins_idx = stale ? free2_idx_q : free_idx_q;
		add_owners = hit_data_q.owners | owner_bit;
		rel_owners = hit_data_q.owners & ~owner_bit;
		rel_after = hit_data_q.was_disabled ? after_or : (cur_q & ~nc_mask_q);
		res = '0;
		res.status = clr_pkg::ST_NOTHING;
		clr_mask = '0;
		set_mask = '0;
		mem_we = 1'b0;
		mem_wa = hit_idx_q;
		mem_wd = hit_data_q;
		if (owner_ok) begin
			unique case (cmd_q)
				clr_pkg::CMD_QUERY: begin
					res.status = clr_pkg::ST_DONE;
					res.lease_held = held_q;
				end
				clr_pkg::CMD_ACQUIRE: begin
					if (!wp_q || body_q == inv_body_q || !snap_ok_q) begin
						res.status = clr_pkg::ST_READ_FAIL;
					end else begin
						// changed identity drops the old lease even if a later step fails
						if (stale) clr_mask = match_q;
						if (!filt_ok_q) begin
							res.status = clr_pkg::ST_READ_FAIL;
						end else if (found_q && !stale &&
							(|(hit_data_q.owners & owner_bit))) begin
							res.status = clr_pkg::ST_DONE;
							res.already_held = 1'b1;
							res.was_disabled_before = hit_data_q.was_disabled;
							res.lease_count = clr_pkg::count_owners(hit_data_q.owners);
						end else if (!found_q || stale) begin
							if (!ins_ok) begin
								res.status = clr_pkg::ST_FULL;
							end else begin
								res.status = clr_pkg::ST_DONE;
								res.first_lease = 1'b1;
								res.was_disabled_before = |(cur_q & nc_mask_q);
								res.lease_count = clr_pkg::count_owners(owner_bit);
								set_mask = clr_pkg::ENTRIES'(1) << ins_idx;
								mem_we = commit;
								mem_wa = ins_idx;
								mem_wd.world = world_q;
								mem_wd.body = body_q;
								mem_wd.motion = motion_q;
								mem_wd.cobj = cobj_q;
								mem_wd.onode = onode_q;
								mem_wd.owners = owner_bit;
								mem_wd.was_disabled = |(cur_q & nc_mask_q);
							end
						end else begin
							res.status = clr_pkg::ST_DONE;
							res.was_disabled_before = hit_data_q.was_disabled;
							res.lease_count = clr_pkg::count_owners(add_owners);
							mem_we = commit;
							mem_wd.owners = add_owners;
						end
						if (filt_ok_q && res.status == clr_pkg::ST_DONE) begin
							res.filter_before = cur_q;
							res.filter_after = after_or;
							res.filter_write = after_or != cur_q;
						end
					end
				end
				clr_pkg::CMD_RELEASE: begin
					if (!wp_q) begin
						res.status = held_q ? clr_pkg::ST_READ_FAIL : clr_pkg::ST_NOTHING;
						res.lease_held = held_q;
					end else if (!found_q) begin
						res.status = clr_pkg::ST_NOTHING;
					end else if (!snap_ok_q || !id_ok) begin
						res.status = clr_pkg::ST_DONE;
						res.stale_dropped = 1'b1;
						res.fully_released = 1'b1;
						res.was_disabled_before = hit_data_q.was_disabled;
						clr_mask = match_q;
					end else if (!filt_ok_q) begin
						res.status = clr_pkg::ST_READ_FAIL;
					end else begin
						res.status = clr_pkg::ST_DONE;
						res.was_disabled_before = hit_data_q.was_disabled;
						res.lease_count = clr_pkg::count_owners(rel_owners);
						res.filter_before = cur_q;
						if (|rel_owners) begin
							res.filter_after = after_or;
							res.filter_write = after_or != cur_q;
							mem_we = commit;
							mem_wd.owners = rel_owners;
						end else begin
							// last holder gone: restore the remembered bit
							res.filter_after = rel_after;
							res.filter_write = rel_after != cur_q;
							res.fully_released = 1'b1;
							clr_mask = match_q;
						end
					end
				end
				default: res.status = clr_pkg::ST_NOTHING;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				valid_q <= (valid_q & ~clr_mask) | set_mask;
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit) res_q <= res;
	end

	assign out_valid = out_valid_q;
	assign status = res_q.status;
	assign already_held = res_q.already_held;
	assign first_lease = res_q.first_lease;
	assign stale_dropped = res_q.stale_dropped;
	assign fully_released = res_q.fully_released;
	assign was_disabled_before = res_q.was_disabled_before;
	assign lease_count = res_q.lease_count;
	assign filter_before = res_q.filter_before;
	assign filter_after = res_q.filter_after;
	assign filter_write = res_q.filter_write;
	assign lease_held = res_q.lease_held;

endmodule

// ----- hdl/clr_checker.sv -----
// port-level checks of the collision lease registry, bound to the top level
// depends on clr_pkg and collision_lease_registry_defines.svh
`include "collision_lease_registry_defines.svh"

module clr_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic        already_held,
	input logic        first_lease,
	input logic        stale_dropped,
	input logic        fully_released,
	input logic [2:0]  lease_count,
	input logic [31:0] filter_before,
	input logic [31:0] filter_after,
	input logic        filter_write
);

	// an accepted item keeps the block busy for its scan
	`CLR_ASSERT_NEXT(a_busy_after_accept, in_valid && !in_stall, in_stall && !$rose(out_valid), "item accepted but block not busy or result too early")

	// filter write flag follows the two filter words
	`CLR_ASSERT_NOW(a_filter_write, out_valid, filter_write == (filter_after != filter_before), "filter_write disagrees with filter words")

	// a full table result reports no lease and no filter write
	`CLR_ASSERT_NOW(a_full_quiet, out_valid && status == clr_pkg::ST_FULL, !first_lease && !already_held && lease_count == 3'd0 && !filter_write, "table full result carries lease data")

	// a stale drop always frees the entry with no holders left
	`CLR_ASSERT_NOW(a_stale_frees, out_valid && stale_dropped, fully_released && lease_count == 3'd0 && status == clr_pkg::ST_DONE, "stale drop without full release")

	// a stalled result stays
	`CLR_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(filter_after), "stalled result dropped or changed")

endmodule

bind collision_lease_registry clr_checker u_clr_checker (
	.clk(clk),
	.arst_n(arst_n),
	.in_valid(in_valid),
	.in_stall(in_stall),
	.out_valid(out_valid),
	.out_stall(out_stall),
	.status(status),
	.already_held(already_held),
	.first_lease(first_lease),
	.stale_dropped(stale_dropped),
	.fully_released(fully_released),
	.lease_count(lease_count),
	.filter_before(filter_before),
	.filter_after(filter_after),
	.filter_write(filter_write)
);

// ----- sim/testbench.sv -----
// self-checking bench for collision_lease_registry: directed lease cases, then random traffic
// needs clr_pkg and the registry rtl; a scoreboard class predicts each result from the items
// accepted, and random input gaps, output stalls and one long output hold-off stress the flow
module testbench;

	localparam int POOL = 24;
	localparam int PHASES = 6;
	localparam int PHASE_ITEMS = 215;
	localparam int HOLD_CYCLES = 400;
	localparam int QUIET_LIMIT = 4000;
	localparam int SETTLE = 30;

	typedef struct packed {
		logic [1:0]  command;
		logic        world_present;
		logic [7:0]  world_id;
		logic [31:0] body_id;
		logic [1:0]  owner;
		logic        snapshot_ok;
		logic [31:0] motion_index;
		logic [31:0] collision_object_id;
		logic [31:0] owner_node_id;
		logic        filter_ok;
		logic [31:0] current_filter;
	} lease_req_t;

	typedef struct packed {
		clr_pkg::status_t status;
		logic        already_held;
		logic        first_lease;
		logic        stale_dropped;
		logic        fully_released;
		logic        was_disabled_before;
		logic [2:0]  lease_count;
		logic [31:0] filter_before;
		logic [31:0] filter_after;
		logic        filter_write;
		logic        lease_held;
	} lease_result_t;

	typedef struct packed {
		logic [7:0]                 world;
		logic [31:0]                body;
		logic [31:0]                motion;
		logic [31:0]                cobj;
		logic [31:0]                onode;
		logic [clr_pkg::OWNERS-1:0] owners;
		logic                       was_off;
	} lease_slot_t;

	class lease_scoreboard;
		logic [31:0]   nc_mask;
		logic [31:0]   bad_body;
		bit            live[clr_pkg::ENTRIES];
		lease_slot_t   slots[clr_pkg::ENTRIES];
		lease_result_t expected_q[$];
		int            errors;

		function new();
			nc_mask = 32'h0000_4000;
			bad_body = 32'h7FFF_FFFF;
			foreach (live[i]) live[i] = 1'b0;
			errors = 0;
		endfunction

		function void set_reg(clr_pkg::reg_idx_t idx, logic [31:0] value);
			case (idx)
				clr_pkg::REG_NO_COLLIDE_MASK: nc_mask = value;
				clr_pkg::REG_INVALID_BODY: bad_body = value;
				default: ;
			endcase
		endfunction

		// lowest live entry for this world and body, -1 when none
		function int find(logic [7:0] world, logic [31:0] body);
			for (int i = 0; i < clr_pkg::ENTRIES; i++) begin
				if (live[i] && slots[i].world == world && slots[i].body == body) return i;
			end
			return -1;
		endfunction

		function void drop(logic [7:0] world, logic [31:0] body);
			for (int i = 0; i < clr_pkg::ENTRIES; i++) begin
				if (live[i] && slots[i].world == world && slots[i].body == body) live[i] = 1'b0;
			end
		endfunction

		function bit held_any(logic [31:0] body, logic [clr_pkg::OWNERS-1:0] obit);
			for (int i = 0; i < clr_pkg::ENTRIES; i++) begin
				if (live[i] && slots[i].body == body && (slots[i].owners & obit) != '0) return 1'b1;
			end
			return 1'b0;
		endfunction

		function bit same_identity(int idx, lease_req_t r);
			return slots[idx].motion == r.motion_index && slots[idx].cobj == r.collision_object_id
				&& slots[idx].onode == r.owner_node_id;
		endfunction

		function void note_request(lease_req_t r);
			lease_result_t res;
			logic [clr_pkg::OWNERS-1:0] obit;
			logic [31:0] after;
			int idx;
			int slot;
			bit held;
			res = '0;
			res.status = clr_pkg::ST_NOTHING;
			obit = '0;
			if (r.owner < clr_pkg::OWNERS) begin
				obit[r.owner] = 1'b1;
				case (r.command)
					clr_pkg::CMD_QUERY: begin
						res.status = clr_pkg::ST_DONE;
						res.lease_held = held_any(r.body_id, obit);
					end
					clr_pkg::CMD_ACQUIRE: begin
						if (!r.world_present || r.body_id == bad_body || !r.snapshot_ok) begin
							res.status = clr_pkg::ST_READ_FAIL;
						end else begin
							idx = find(r.world_id, r.body_id);
							// body changed under the lease: old entry goes even if the rest fails
							if (idx >= 0 && !same_identity(idx, r)) begin
								drop(r.world_id, r.body_id);
								idx = -1;
							end
							if (!r.filter_ok) begin
								res.status = clr_pkg::ST_READ_FAIL;
							end else begin
								if (idx < 0) begin
									slot = 0;
									while (slot < clr_pkg::ENTRIES && live[slot]) slot++;
									if (slot < clr_pkg::ENTRIES) begin
										idx = slot;
										live[idx] = 1'b1;
										slots[idx].world = r.world_id;
										slots[idx].body = r.body_id;
										slots[idx].motion = r.motion_index;
										slots[idx].cobj = r.collision_object_id;
										slots[idx].onode = r.owner_node_id;
										slots[idx].owners = obit;
										slots[idx].was_off = (r.current_filter & nc_mask) != '0;
										res.first_lease = 1'b1;
									end
								end else if ((slots[idx].owners & obit) != '0) begin
									res.already_held = 1'b1;
								end else begin
									slots[idx].owners |= obit;
								end
								if (idx < 0) begin
									res.status = clr_pkg::ST_FULL;
								end else begin
									after = r.current_filter | nc_mask;
									res.status = clr_pkg::ST_DONE;
									res.was_disabled_before = slots[idx].was_off;
									res.lease_count = 3'($countones(slots[idx].owners));
									res.filter_before = r.current_filter;
									res.filter_after = after;
									res.filter_write = after != r.current_filter;
								end
							end
						end
					end
					clr_pkg::CMD_RELEASE: begin
						if (!r.world_present) begin
							held = held_any(r.body_id, obit);
							res.status = held ? clr_pkg::ST_READ_FAIL : clr_pkg::ST_NOTHING;
							res.lease_held = held;
						end else begin
							idx = find(r.world_id, r.body_id);
							if (idx >= 0) begin
								if (!r.snapshot_ok || !same_identity(idx, r)) begin
									res.status = clr_pkg::ST_DONE;
									res.stale_dropped = 1'b1;
									res.fully_released = 1'b1;
									res.was_disabled_before = slots[idx].was_off;
									drop(r.world_id, r.body_id);
								end else if (!r.filter_ok) begin
									res.status = clr_pkg::ST_READ_FAIL;
								end else begin
									// a non-holder leaves the mask alone but still gets a filter word
									slots[idx].owners &= ~obit;
									res.status = clr_pkg::ST_DONE;
									res.was_disabled_before = slots[idx].was_off;
									res.lease_count = 3'($countones(slots[idx].owners));
									res.filter_before = r.current_filter;
									if (slots[idx].owners != '0) begin
										after = r.current_filter | nc_mask;
									end else begin
										after = slots[idx].was_off ? (r.current_filter | nc_mask)
											: (r.current_filter & ~nc_mask);
										res.fully_released = 1'b1;
										drop(r.world_id, r.body_id);
									end
									res.filter_after = after;
									res.filter_write = after != r.current_filter;
								end
							end
						end
					end
					default: ;
				endcase
			end
			expected_q = {expected_q, res};
		endfunction

		function void compare_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				if (errors < 50)
					$display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_result(lease_result_t got);
			lease_result_t want;
			if (expected_q.size() == 0) begin
				if (errors < 50) $display("%0t: result with no item pending, status %0d", $time, got.status);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("status", want.status, got.status);
			compare_field("already_held", want.already_held, got.already_held);
			compare_field("first_lease", want.first_lease, got.first_lease);
			compare_field("stale_dropped", want.stale_dropped, got.stale_dropped);
			compare_field("fully_released", want.fully_released, got.fully_released);
			compare_field("was_disabled_before", want.was_disabled_before, got.was_disabled_before);
			compare_field("lease_count", want.lease_count, got.lease_count);
			compare_field("filter_before", want.filter_before, got.filter_before);
			compare_field("filter_after", want.filter_after, got.filter_after);
			compare_field("filter_write", want.filter_write, got.filter_write);
			compare_field("lease_held", want.lease_held, got.lease_held);
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  command = '0;
	logic        world_present = 1'b0;
	logic [7:0]  world_id = '0;
	logic [31:0] body_id = '0;
	logic [1:0]  owner = '0;
	logic        snapshot_ok = 1'b0;
	logic [31:0] motion_index = '0;
	logic [31:0] collision_object_id = '0;
	logic [31:0] owner_node_id = '0;
	logic        filter_ok = 1'b0;
	logic [31:0] current_filter = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic [1:0]  status;
	logic        already_held;
	logic        first_lease;
	logic        stale_dropped;
	logic        fully_released;
	logic        was_disabled_before;
	logic [2:0]  lease_count;
	logic [31:0] filter_before;
	logic [31:0] filter_after;
	logic        filter_write;
	logic        lease_held;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [1:0]  cfg_index = '0;
	logic [31:0] cfg_data = '0;

	lease_scoreboard sb;
	bit no_gaps = 1'b0;
	bit hold_req = 1'b0;
	int quiet = 0;

	// bodies the random traffic works on, with their current identity
	logic [7:0]  key_world[POOL];
	logic [31:0] key_body[POOL];
	logic [31:0] key_motion[POOL];
	logic [31:0] key_cobj[POOL];
	logic [31:0] key_onode[POOL];

	collision_lease_registry u_dut (.*);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < 45) return 0;
		if (roll < 85) return $urandom_range(1, 3);
		if (roll < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic lease_req_t pool_req(clr_pkg::cmd_t cmd, int k, int own);
		lease_req_t r;
		r.command = cmd;
		r.world_present = 1'b1;
		r.world_id = key_world[k];
		r.body_id = key_body[k];
		r.owner = own[1:0];
		r.snapshot_ok = 1'b1;
		r.motion_index = key_motion[k];
		r.collision_object_id = key_cobj[k];
		r.owner_node_id = key_onode[k];
		r.filter_ok = 1'b1;
		r.current_filter = $urandom;
		return r;
	endfunction

	function automatic lease_req_t random_req();
		lease_req_t r;
		logic [191:0] raw;
		clr_pkg::cmd_t cmd;
		int k;
		int roll;
		if ($urandom_range(0, 99) < 15) begin
			raw = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
			return raw[$bits(lease_req_t)-1:0];
		end
		k = $urandom_range(0, POOL - 1);
		roll = $urandom_range(0, 99);
		cmd = (roll < 48) ? clr_pkg::CMD_ACQUIRE
			: (roll < 85) ? clr_pkg::CMD_RELEASE : clr_pkg::CMD_QUERY;
		// the body behind a key gets replaced now and then
		if ($urandom_range(0, 49) == 0) begin
			case ($urandom_range(0, 2))
				0: key_motion[k] = $urandom;
				1: key_cobj[k] = $urandom;
				default: key_onode[k] = $urandom;
			endcase
		end
		r = pool_req(cmd, k, $urandom_range(0, clr_pkg::OWNERS - 1));
		if ($urandom_range(0, 29) == 0) r.world_present = 1'b0;
		if ($urandom_range(0, 24) == 0) r.snapshot_ok = 1'b0;
		if ($urandom_range(0, 24) == 0) r.filter_ok = 1'b0;
		if ($urandom_range(0, 29) == 0) r.owner_node_id ^= 32'h1 << $urandom_range(0, 31);
		return r;
	endfunction

	task automatic send_item(input lease_req_t r);
		int gap;
		gap = no_gaps ? 0 : pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		command <= r.command;
		world_present <= r.world_present;
		world_id <= r.world_id;
		body_id <= r.body_id;
		owner <= r.owner;
		snapshot_ok <= r.snapshot_ok;
		motion_index <= r.motion_index;
		collision_object_id <= r.collision_object_id;
		owner_node_id <= r.owner_node_id;
		filter_ok <= r.filter_ok;
		current_filter <= r.current_filter;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		sb.note_request(r);
	endtask

	task automatic configure(input logic [31:0] mask, input logic [31:0] body);
		cfg_valid <= 1'b1;
		cfg_index <= clr_pkg::REG_NO_COLLIDE_MASK;
		cfg_data <= mask;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(clr_pkg::REG_NO_COLLIDE_MASK, mask);
		cfg_index <= clr_pkg::REG_INVALID_BODY;
		cfg_data <= body;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		sb.set_reg(clr_pkg::REG_INVALID_BODY, body);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		in_valid <= 1'b0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// output side: random stalls, quiet runs, and one long hold-off on request
	initial begin : out_side
		int n;
		wait (arst_n);
		forever begin
			if (hold_req) begin
				hold_req = 1'b0;
				out_stall <= 1'b1;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				n = pick_gap();
				if (n > 0) begin
					out_stall <= 1'b1;
					repeat (n) @(posedge clk);
				end
			end
			out_stall <= 1'b0;
			repeat (($urandom_range(0, 19) == 0) ? $urandom_range(50, 200) : $urandom_range(1, 6))
				@(posedge clk);
		end
	end

	always @(posedge clk) begin : result_watch
		lease_result_t got;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got.status = clr_pkg::status_t'(status);
				got.already_held = already_held;
				got.first_lease = first_lease;
				got.stale_dropped = stale_dropped;
				got.fully_released = fully_released;
				got.was_disabled_before = was_disabled_before;
				got.lease_count = lease_count;
				got.filter_before = filter_before;
				got.filter_after = filter_after;
				got.filter_write = filter_write;
				got.lease_held = lease_held;
				sb.check_result(got);
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
				quiet = 0;
			end else begin
				quiet++;
				if (quiet >= QUIET_LIMIT) begin
					$display("testbench: FAIL");
					$finish;
				end
			end
		end
	end

	initial begin : stimulus
		logic [31:0] mask_set[PHASES];
		logic [31:0] body_set[PHASES];
		lease_req_t r;
		sb = new();
		for (int k = 0; k < POOL; k++) begin
			key_world[k] = $urandom_range(0, 255);
			// some keys share a body across worlds
			key_body[k] = (k % 4 == 3) ? key_body[k - 1] : $urandom;
			key_motion[k] = $urandom;
			key_cobj[k] = $urandom;
			key_onode[k] = $urandom;
		end
		key_world[0] = 8'h00;
		key_body[0] = 32'h0000_0000;
		key_world[1] = 8'hFF;
		key_body[1] = 32'hFFFF_FFFF;
		mask_set = '{32'h0000_4000, 32'h0000_0000, 32'hFFFF_FFFF, 32'h1 << $urandom_range(0, 31),
			32'h8000_0000, $urandom};
		body_set = '{32'h7FFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, key_body[5], $urandom,
			32'h7FFF_FFFF};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// acquire refusals
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 0);
		r.world_present = 1'b0;
		send_item(r);
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 0);
		r.body_id = 32'h7FFF_FFFF;
		send_item(r);
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 0);
		r.snapshot_ok = 1'b0;
		send_item(r);
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 0);
		r.filter_ok = 1'b0;
		send_item(r);
		// two owners on one body, queries and world-less release
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 0);
		r.current_filter = 32'h0000_0000;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_ACQUIRE, 0, 0));
		r = pool_req(clr_pkg::CMD_ACQUIRE, 0, 3);
		r.current_filter = 32'hFFFF_FFFF;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_QUERY, 0, 3));
		send_item(pool_req(clr_pkg::CMD_QUERY, 0, 1));
		r = pool_req(clr_pkg::CMD_RELEASE, 0, 3);
		r.world_present = 1'b0;
		send_item(r);
		r = pool_req(clr_pkg::CMD_RELEASE, 1, 0);
		r.world_present = 1'b0;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_RELEASE, 1, 0));
		r = pool_req(clr_pkg::CMD_RELEASE, 0, 0);
		r.filter_ok = 1'b0;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_RELEASE, 0, 1));
		send_item(pool_req(clr_pkg::CMD_RELEASE, 0, 0));
		send_item(pool_req(clr_pkg::CMD_RELEASE, 0, 3));
		// identity changes on acquire and release
		r = pool_req(clr_pkg::CMD_ACQUIRE, 1, 2);
		r.current_filter = 32'hFFFF_FFFF;
		send_item(r);
		key_motion[1] = ~key_motion[1];
		send_item(pool_req(clr_pkg::CMD_ACQUIRE, 1, 1));
		key_cobj[1] = ~key_cobj[1];
		r = pool_req(clr_pkg::CMD_ACQUIRE, 1, 1);
		r.filter_ok = 1'b0;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_ACQUIRE, 2, 1));
		r = pool_req(clr_pkg::CMD_RELEASE, 2, 1);
		r.snapshot_ok = 1'b0;
		send_item(r);
		send_item(pool_req(clr_pkg::CMD_ACQUIRE, 2, 0));
		r = pool_req(clr_pkg::CMD_RELEASE, 2, 0);
		r.owner_node_id = ~r.owner_node_id;
		send_item(r);
		r = pool_req(clr_pkg::CMD_QUERY, 2, 0);
		r.command = 2'd3;
		send_item(r);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			configure(mask_set[p], body_set[p]);
			no_gaps = (p == 1);
			if (p == 2) hold_req = 1'b1;
			repeat (PHASE_ITEMS) send_item(random_req());
			settle();
		end

		if (sb.errors == 0) $display("testbench: PASS");
		else $display("testbench: FAIL");
		$finish;
	end
endmodule

// ----- files.f -----
+incdir+hdl
hdl/clr_pkg.sv
hdl/collision_lease_registry.sv
hdl/clr_checker.sv
sim/testbench.sv
